// ===== sv/abd_pkg.sv =====
package abd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 8;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int PRED_SH  = 6;
    localparam int STEP_W   = 3;

    localparam logic [3:0] POS_HEADER = 4'd0;
    localparam logic [3:0] POS_FLAGS  = 4'd1;
    localparam logic [3:0] POS_LAST   = 4'd15;
    localparam logic [3:0] FILT_MAX   = 4'd4;

    localparam logic [7:0] FLAG_END   = 8'h01;
    localparam logic [7:0] FLAG_LOOP  = 8'h03;
    localparam logic [7:0] FLAG_START = 8'h04;

    typedef enum logic [1:0] {
        ACT_CONTINUE = 2'd0,
        ACT_JUMP     = 2'd1,
        ACT_STOP     = 2'd2
    } t_action;

    // datapath operation of one microcode step
    typedef enum logic [2:0] {
        UOP_FETCH = 3'd0,
        UOP_MUL   = 3'd1,
        UOP_SUM   = 3'd2,
        UOP_SAT   = 3'd3,
        UOP_PUT   = 3'd4
    } t_uop;

    typedef enum logic [1:0] {
        JMP_NEXT  = 2'd0,
        JMP_FETCH = 2'd1,
        JMP_PUT   = 2'd2
    } t_jump;

    typedef struct packed {
        t_uop              uop;
        logic              nib_hi;
        t_jump             jump;
        logic [STEP_W-1:0] target;
    } t_uword;

    localparam logic [STEP_W-1:0] STEP_FETCH = 3'd0;
    localparam logic [STEP_W-1:0] STEP_PUT   = 3'd7;

    // fetch, low nibble pass, high nibble pass, hand over the word
    function automatic t_uword urom(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            3'd0: w = '{UOP_FETCH, 1'b0, JMP_FETCH, STEP_PUT};
            3'd1: w = '{UOP_MUL,   1'b0, JMP_NEXT,  STEP_FETCH};
            3'd2: w = '{UOP_SUM,   1'b0, JMP_NEXT,  STEP_FETCH};
            3'd3: w = '{UOP_SAT,   1'b0, JMP_NEXT,  STEP_FETCH};
            3'd4: w = '{UOP_MUL,   1'b1, JMP_NEXT,  STEP_FETCH};
            3'd5: w = '{UOP_SUM,   1'b1, JMP_NEXT,  STEP_FETCH};
            3'd6: w = '{UOP_SAT,   1'b1, JMP_NEXT,  STEP_FETCH};
            3'd7: w = '{UOP_PUT,   1'b0, JMP_PUT,   STEP_FETCH};
        endcase
        return w;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_one(input logic [2:0] filt);
        logic signed [COEF_W-1:0] k;
        unique case (filt)
            3'd1:    k = 8'sd60;
            3'd2:    k = 8'sd115;
            3'd3:    k = 8'sd98;
            3'd4:    k = 8'sd122;
            default: k = 8'sd0;
        endcase
        return k;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_two(input logic [2:0] filt);
        logic signed [COEF_W-1:0] k;
        unique case (filt)
            3'd2:    k = -8'sd52;
            3'd3:    k = -8'sd55;
            3'd4:    k = -8'sd60;
            default: k = 8'sd0;
        endcase
        return k;
    endfunction

endpackage

// ===== sv/abd_if.sv =====
interface abd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, data_byte, restart, input ready);
    modport sink   (input valid, data_byte, restart, output ready);
endinterface

interface abd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [abd_pkg::SAMPLE_W-1:0] sample_first;
    logic signed [abd_pkg::SAMPLE_W-1:0] sample_second;
    logic                                 last_in_block;
    logic [1:0]                           block_action;
    logic                                 loop_start_mark;
    logic                                 bad_filter;

    modport source (output valid, sample_first, sample_second, last_in_block,
                    block_action, loop_start_mark, bad_filter, input ready);
    modport sink   (input valid, sample_first, sample_second, last_in_block,
                    block_action, loop_start_mark, bad_filter, output ready);
endinterface

// ===== sv/adpcm_block_decoder.sv =====
// 4-bit ADPCM block decoder, one byte of a 16-byte block per input word.
// i_in carries data_byte and restart; a word is taken when valid and ready
// are both high. restart marks byte 0 of a new voice and clears the history,
// the block position and the stop state before the byte is used.
// Bytes 0 and 1 (header and flags) are taken at the fetch step and give no output.
// Each of bytes 2 to 15 gives one word on o_out with both samples, the
// block-end action, the loop start mark and the bad filter flag.
// A data byte runs an eight-step microcode program: fetch, then per nibble a
// registered multiply of both history taps, their sum, and the shift, add and
// saturate, then the hand-over to the output register. The block takes a new
// data byte only when the program is back at the fetch step, as the history
// chain from one nibble to the next keeps the steps of a byte in order.
// A data byte of a stopped voice skips the decode steps to the hand-over step.
// The output register lets the next byte be fetched and decoded while a
// result waits; if the receiver stalls longer, the program holds at the
// hand-over step and i_in.ready stays low until the word is taken.
// After reset (i_rst_n low, synchronous) the history and position are zero
// and no output word is pending.
module adpcm_block_decoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    abd_in_if.sink          i_in,
    abd_out_if.source       o_out
);

    localparam int SW = abd_pkg::SAMPLE_W;
    localparam int AW = abd_pkg::ACC_W;
    localparam int PW = abd_pkg::PROD_W;
    localparam int VW = AW - abd_pkg::PRED_SH + 1;

    abd_pkg::t_uword uw;

    logic [abd_pkg::STEP_W-1:0] r_step, n_step;
    logic [3:0]  r_pos;
    logic [3:0]  r_shift;
    logic [3:0]  r_filt;
    logic [7:0]  r_flags;
    logic        r_stop;
    logic signed [SW-1:0] r_h1, r_h2;

    logic [7:0]  r_byte;
    logic signed [PW-1:0] r_p1, r_p2;
    logic signed [AW-1:0] r_acc;
    logic signed [SW-1:0] r_s0, r_s1;
    logic        r_last, r_loop, r_bad;
    abd_pkg::t_action r_act;

    logic        r_ovalid;
    logic signed [SW-1:0] r_o_s0, r_o_s1;
    logic        r_o_last, r_o_loop, r_o_bad;
    logic [1:0]  r_o_act;

    logic        in_ready, accept, out_free, bad_now;
    logic [3:0]  eff_pos;
    logic [2:0]  feff;
    logic [3:0]  nib;
    logic signed [SW-1:0] nib_val;
    logic signed [VW-1:0] sum_v;
    logic signed [SW-1:0] sat_v;
    abd_pkg::t_action act_now;

    always_comb begin
        uw       = abd_pkg::urom(r_step);
        in_ready = (uw.uop == abd_pkg::UOP_FETCH);
        accept   = i_in.valid && in_ready;
        out_free = !r_ovalid || o_out.ready;
        eff_pos  = i_in.restart ? abd_pkg::POS_HEADER : r_pos;
        bad_now  = (r_filt > abd_pkg::FILT_MAX);
        feff     = bad_now ? 3'd0 : r_filt[2:0];

        if (eff_pos == abd_pkg::POS_LAST
                && (r_flags & abd_pkg::FLAG_END) == abd_pkg::FLAG_END) begin
            act_now = ((r_flags & abd_pkg::FLAG_LOOP) == abd_pkg::FLAG_LOOP)
                      ? abd_pkg::ACT_JUMP : abd_pkg::ACT_STOP;
        end else begin
            act_now = abd_pkg::ACT_CONTINUE;
        end

        // nibble in the top bits, then the arithmetic shift
        nib     = uw.nib_hi ? r_byte[7:4] : r_byte[3:0];
        nib_val = $signed({nib, 12'b0}) >>> r_shift;
        sum_v   = VW'(nib_val) + VW'(r_acc >>> abd_pkg::PRED_SH);
        if (sum_v > VW'(32767)) begin
            sat_v = 16'sh7FFF;
        end else if (sum_v < -VW'(32768)) begin
            sat_v = -16'sh8000;
        end else begin
            sat_v = sum_v[SW-1:0];
        end

        n_step = r_step;
        unique case (uw.jump)
            abd_pkg::JMP_FETCH: begin
                if (accept && eff_pos != abd_pkg::POS_HEADER
                        && eff_pos != abd_pkg::POS_FLAGS) begin
                    n_step = r_stop ? uw.target : r_step + 1'b1;
                end
            end
            abd_pkg::JMP_NEXT: n_step = r_step + 1'b1;
            abd_pkg::JMP_PUT: begin
                if (out_free) n_step = uw.target;
            end
            default: n_step = r_step;
        endcase
    end

    assign i_in.ready            = in_ready;
    assign o_out.valid           = r_ovalid;
    assign o_out.sample_first    = r_o_s0;
    assign o_out.sample_second   = r_o_s1;
    assign o_out.last_in_block   = r_o_last;
    assign o_out.block_action    = r_o_act;
    assign o_out.loop_start_mark = r_o_loop;
    assign o_out.bad_filter      = r_o_bad;

    // control and decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= abd_pkg::STEP_FETCH;
            r_pos    <= '0;
            r_shift  <= '0;
            r_filt   <= '0;
            r_flags  <= '0;
            r_stop   <= 1'b0;
            r_h1     <= '0;
            r_h2     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (accept) begin
                r_pos <= eff_pos + 1'b1;
                if (i_in.restart) begin
                    r_h1   <= '0;
                    r_h2   <= '0;
                    r_stop <= 1'b0;
                end
                if (eff_pos == abd_pkg::POS_HEADER) begin
                    r_shift <= i_in.data_byte[3:0];
                    r_filt  <= i_in.data_byte[7:4];
                end else if (eff_pos == abd_pkg::POS_FLAGS) begin
                    r_flags <= i_in.data_byte;
                end else if (!r_stop && act_now == abd_pkg::ACT_STOP) begin
                    r_stop <= 1'b1;
                end
            end
            if (uw.uop == abd_pkg::UOP_SAT) begin
                r_h2 <= r_h1;
                r_h1 <= sat_v;
            end
            if (uw.uop == abd_pkg::UOP_PUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath words, no reset
    always_ff @(posedge i_clk) begin
        unique case (uw.uop)
            abd_pkg::UOP_FETCH: begin
                r_byte <= i_in.data_byte;
                r_last <= (eff_pos == abd_pkg::POS_LAST);
                r_s0   <= '0;
                r_s1   <= '0;
                if (r_stop) begin
                    r_act  <= abd_pkg::ACT_CONTINUE;
                    r_loop <= 1'b0;
                    r_bad  <= 1'b0;
                end else begin
                    r_act  <= act_now;
                    r_loop <= (r_flags & abd_pkg::FLAG_START) != 8'h00;
                    r_bad  <= bad_now;
                end
            end
            abd_pkg::UOP_MUL: begin
                r_p1 <= r_h1 * abd_pkg::coef_one(feff);
                r_p2 <= r_h2 * abd_pkg::coef_two(feff);
            end
            abd_pkg::UOP_SUM: begin
                r_acc <= AW'(r_p1) + AW'(r_p2);
            end
            abd_pkg::UOP_SAT: begin
                if (uw.nib_hi) r_s1 <= sat_v;
                else           r_s0 <= sat_v;
            end
            abd_pkg::UOP_PUT: begin
                if (out_free) begin
                    r_o_s0   <= r_s0;
                    r_o_s1   <= r_s1;
                    r_o_last <= r_last;
                    r_o_act  <= r_act;
                    r_o_loop <= r_loop;
                    r_o_bad  <= r_bad;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== bench/tb_adpcm_block_decoder.sv =====
`timescale 1ns / 1ps

module tb_adpcm_block_decoder;

    localparam int RANDOM_BYTES  = 450;
    localparam int DRAIN_AFTER   = 150;
    localparam int LONG_HOLD_AT  = 220;
    localparam int LONG_HOLD_LEN = 300;
    localparam int TAIL_CYCLES   = 24;
    localparam int CYCLE_LIMIT   = 400000;

    // two-tap predictor weights, scaled by 64, for filters 0 to 4
    localparam int LAG_ONE_K [5] = '{0, 60, 115, 98, 122};
    localparam int LAG_TWO_K [5] = '{0, 0, -52, -55, -60};

    typedef struct {
        logic [7:0] data_byte;
        logic       restart;
        int         gap;
        bit         drain;
    } t_byte_item;

    typedef struct {
        logic signed [15:0] sample_first;
        logic signed [15:0] sample_second;
        logic               last_in_block;
        abd_pkg::t_action   block_action;
        logic               loop_start_mark;
        logic               bad_filter;
    } t_sample_pair;

    logic i_clk;
    logic i_rst_n;

    abd_in_if  in_bus ();
    abd_out_if out_bus ();

    adpcm_block_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_byte_item   byte_queue [$];
    t_sample_pair pending_pairs [$];
    t_byte_item   next_byte;

    // decoder state as the bench sees it
    logic [3:0]         byte_pos;
    logic [3:0]         shift_amt;
    logic [3:0]         filt_num;
    logic [7:0]         flags_now;
    logic signed [15:0] hist_one;
    logic signed [15:0] hist_two;
    logic               voice_stopped;

    int  fail_count;
    int  results_seen;
    int  cycle_count;
    int  gap_left;
    bit  gap_armed;
    int  stall_left;
    bit  long_hold_done;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [15:0] decode_nibble(input logic [3:0] nib,
                                                         input int k0, input int k1);
        int v;
        int pred;
        v    = (int'($signed(nib)) * 4096) >>> shift_amt;
        pred = (int'(hist_one) * k0 + int'(hist_two) * k1) >>> 6;
        v    = v + pred;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        hist_two = hist_one;
        hist_one = v[15:0];
        return v[15:0];
    endfunction

    // one accepted byte: update state, queue the sample pair it gives if any
    function automatic void predict_word(input logic [7:0] b, input logic rs);
        logic [3:0]   pos;
        logic [2:0]   fsel;
        t_sample_pair p;
        if (rs) begin
            hist_one      = '0;
            hist_two      = '0;
            byte_pos      = '0;
            voice_stopped = 1'b0;
        end
        pos      = byte_pos;
        byte_pos = pos + 4'd1;
        if (pos == abd_pkg::POS_HEADER) begin
            shift_amt = b[3:0];
            filt_num  = b[7:4];
            return;
        end
        if (pos == abd_pkg::POS_FLAGS) begin
            flags_now = b;
            return;
        end
        p.sample_first    = '0;
        p.sample_second   = '0;
        p.block_action    = abd_pkg::ACT_CONTINUE;
        p.loop_start_mark = 1'b0;
        p.last_in_block   = (pos == abd_pkg::POS_LAST);
        p.bad_filter      = (filt_num > abd_pkg::FILT_MAX);
        fsel = p.bad_filter ? 3'd0 : filt_num[2:0];
        if (!voice_stopped) begin
            p.sample_first    = decode_nibble(b[3:0], LAG_ONE_K[fsel], LAG_TWO_K[fsel]);
            p.sample_second   = decode_nibble(b[7:4], LAG_ONE_K[fsel], LAG_TWO_K[fsel]);
            p.loop_start_mark = |(flags_now & abd_pkg::FLAG_START);
            if (p.last_in_block && |(flags_now & abd_pkg::FLAG_END)) begin
                if ((flags_now & abd_pkg::FLAG_LOOP) == abd_pkg::FLAG_LOOP) begin
                    p.block_action = abd_pkg::ACT_JUMP;
                end else begin
                    p.block_action = abd_pkg::ACT_STOP;
                    voice_stopped  = 1'b1;
                end
            end
        end else begin
            p.bad_filter = 1'b0;
        end
        pending_pairs.push_back(p);
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic rs, input int gap,
                              input bit drain);
        t_byte_item it;
        it.data_byte = b;
        it.restart   = rs;
        it.gap       = gap;
        it.drain     = drain;
        byte_queue.push_back(it);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid  <= 1'b0;
            gap_armed     = 1'b0;
            gap_left      = 0;
            byte_pos      = '0;
            shift_amt     = '0;
            filt_num      = '0;
            flags_now     = '0;
            hist_one      = '0;
            hist_two      = '0;
            voice_stopped = 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready)
                predict_word(in_bus.data_byte, in_bus.restart);
            if (!in_bus.valid || in_bus.ready) begin
                if (byte_queue.size() == 0) begin
                    in_bus.valid <= 1'b0;
                end else begin
                    if (!gap_armed) begin
                        gap_left  = byte_queue[0].gap;
                        gap_armed = 1'b1;
                    end
                    if (gap_left > 0) begin
                        gap_left--;
                        in_bus.valid <= 1'b0;
                    end else if (byte_queue[0].drain && pending_pairs.size() != 0) begin
                        // hold until every queued sample pair has come out
                        in_bus.valid <= 1'b0;
                    end else begin
                        next_byte = byte_queue.pop_front();
                        in_bus.valid     <= 1'b1;
                        in_bus.data_byte <= next_byte.data_byte;
                        in_bus.restart   <= next_byte.restart;
                        gap_armed = 1'b0;
                    end
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            stall_left     = 0;
            long_hold_done = 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (pending_pairs.size() == 0) begin
                    $error("sample pair with no word waiting: first %0d, second %0d",
                           out_bus.sample_first, out_bus.sample_second);
                    fail_count++;
                end else begin
                    t_sample_pair want;
                    want = pending_pairs.pop_front();
                    check_field("sample_first", want.sample_first, out_bus.sample_first);
                    check_field("sample_second", want.sample_second,
                                out_bus.sample_second);
                    check_field("last_in_block", want.last_in_block,
                                out_bus.last_in_block);
                    check_field("block_action", want.block_action, out_bus.block_action);
                    check_field("loop_start_mark", want.loop_start_mark,
                                out_bus.loop_start_mark);
                    check_field("bad_filter", want.bad_filter, out_bus.bad_filter);
                end
                results_seen++;
            end
            if (results_seen >= LONG_HOLD_AT && !long_hold_done) begin
                // long back-pressure, the sender keeps offering bytes
                stall_left     = LONG_HOLD_LEN;
                long_hold_done = 1'b1;
            end else if (stall_left == 0 && !(results_seen >= 100 && results_seen < 160)
                         && $urandom_range(5) == 0) begin
                stall_left = rand_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [7:0] hdr;
        logic [7:0] flg;
        logic [7:0] b;
        int         random_count;
        int         n_blocks;
        int         blk_len;
        int         r;
        bit         steady;
        bit         drain_done;
        logic [7:0] edge_bytes [14];

        fail_count       = 0;
        results_seen     = 0;
        cycle_count      = 0;
        i_rst_n          = 1'b0;
        in_bus.valid     = 1'b0;
        in_bus.data_byte = '0;
        in_bus.restart   = 1'b0;
        out_bus.ready    = 1'b0;

        // filter 4, shift 0, loop start and stop flags; nibble extremes drive saturation
        edge_bytes = '{8'h77, 8'h77, 8'h77, 8'h88, 8'h88, 8'h88, 8'h00,
                       8'hFF, 8'h80, 8'h08, 8'h7F, 8'hF7, 8'h0F, 8'hF0};
        queue_byte(8'h40, 1'b1, 0, 1'b0);
        queue_byte(8'h05, 1'b0, 0, 1'b0);
        foreach (edge_bytes[i])
            queue_byte(edge_bytes[i], 1'b0, 0, 1'b0);
        // stopped voice: bad filter and large shift header, data word decodes to zero
        queue_byte(8'h9D, 1'b0, 0, 1'b0);
        queue_byte(8'hFB, 1'b0, 0, 1'b0);
        queue_byte(8'h5A, 1'b0, 0, 1'b0);
        // restart clears the stop; this block is cut short by the next restart
        queue_byte(8'hFF, 1'b1, 0, 1'b0);
        queue_byte(8'hF8, 1'b0, 0, 1'b0);
        queue_byte(8'h87, 1'b0, 0, 1'b0);
        queue_byte(8'h78, 1'b0, 0, 1'b0);
        queue_byte(8'hFF, 1'b0, 0, 1'b0);
        queue_byte(8'h00, 1'b0, 0, 1'b0);

        random_count = 0;
        drain_done   = 1'b0;
        while (random_count < RANDOM_BYTES) begin
            steady   = ($urandom_range(3) == 0);
            n_blocks = $urandom_range(1, 5);
            for (int blk = 0; blk < n_blocks; blk++) begin
                hdr[3:0] = ($urandom_range(99) < 85) ? 4'($urandom_range(12))
                                                     : 4'($urandom_range(13, 15));
                hdr[7:4] = ($urandom_range(99) < 80) ? 4'($urandom_range(4))
                                                     : 4'($urandom_range(5, 15));
                flg = 8'($urandom_range(255));
                r   = $urandom_range(99);
                if (r < 65)
                    flg[1:0] = 2'b00;
                else if (r < 72)
                    flg[1:0] = 2'b10;
                else if (r < 86)
                    flg[1:0] = 2'b11;
                else
                    flg[1:0] = 2'b01;
                blk_len = ($urandom_range(9) == 0) ? $urandom_range(1, 15) : 16;
                for (int k = 0; k < blk_len; k++) begin
                    if (k == 0)
                        b = hdr;
                    else if (k == 1)
                        b = flg;
                    else
                        b = 8'($urandom_range(255));
                    if (blk == 0 && k == 0 && !drain_done && random_count >= DRAIN_AFTER) begin
                        queue_byte(b, 1'b1, steady ? 0 : rand_gap(), 1'b1);
                        drain_done = 1'b1;
                    end else begin
                        queue_byte(b, blk == 0 && k == 0, steady ? 0 : rand_gap(), 1'b0);
                    end
                    random_count++;
                end
                // a cut block is dropped by the restart of the next voice
                if (blk_len < 16)
                    break;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_queue.size() != 0 || in_bus.valid || pending_pairs.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
